// ===== rtl/lpd_pkg.sv =====
`default_nettype none
package lpd_pkg;

	// field widths
	localparam int DATA_W    = 8;
	localparam int LEN_W     = 7;
	localparam int CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 1'd1;

	// configuration reset values
	localparam logic [DATA_W-1:0] START_MARKER_RST = 8'd126;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 7'd64;

	// controller to datapath
	typedef struct packed {
		logic latch_len;
		logic clr_cnt;
		logic store;
		logic emit_step;
	} lpd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_marker;
		logic is_zero;
		logic too_long;
		logic cnt_full;
		logic frame_done;
		logic near_full;
		logic rd_last;
		logic out_free;
	} lpd_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lpd_ram.sv =====
`default_nettype none
module lpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/lpd_ctrl.sv =====
`default_nettype none
module lpd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lpd_pkg::lpd_stat_t stat,
	output lpd_pkg::lpd_cmd_t      cmd
);
	import lpd_pkg::*;

	localparam logic [1:0] ST_HUNT = 2'd0;
	localparam logic [1:0] ST_LEN  = 2'd1;
	localparam logic [1:0] ST_DATA = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// input is stalled only while a message is read out
	assign in_ready = (state_q != ST_EMIT);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		if (accept && stat.is_marker) begin
			state_d     = ST_LEN;
			cmd.clr_cnt = 1'b1;
		end else begin
			case (state_q)
				ST_LEN: begin
					if (accept && !stat.is_zero) begin
						if (stat.too_long) begin
							state_d = ST_HUNT;
						end else begin
							cmd.latch_len = 1'b1;
							cmd.clr_cnt   = 1'b1;
							state_d       = ST_DATA;
						end
					end
				end
				ST_DATA: begin
					if (accept) begin
						if (stat.cnt_full) begin
							state_d = ST_HUNT;
						end else begin
							cmd.store = 1'b1;
							if (stat.frame_done) begin
								state_d = ST_EMIT;
							end else if (stat.near_full) begin
								state_d = ST_HUNT;
							end
						end
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						cmd.emit_step = 1'b1;
						if (stat.rd_last) begin
							state_d = ST_HUNT;
						end
					end
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LEN;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// readout only leaves for hunting, never straight into a new frame
	a_emit_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && state_d != ST_EMIT) |-> (state_d == ST_HUNT))
		else $error("readout left to a state other than hunting");
	// a frame is only entered with a latched length
	a_data_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DATA && state_d == ST_DATA) |-> cmd.latch_len)
		else $error("receive entered without a length");
`endif

endmodule
`default_nettype wire

// ===== rtl/lpd_dp.sv =====
`default_nettype none
module lpd_dp #(
	parameter int BUF_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lpd_pkg::DATA_W-1:0]     cfg_data,
	input  wire logic [lpd_pkg::DATA_W-1:0]     rx_byte,
	input  wire lpd_pkg::lpd_cmd_t              cmd,
	output lpd_pkg::lpd_stat_t                  stat,
	output logic      [lpd_pkg::DATA_W-1:0]     payload_byte,
	output logic      [lpd_pkg::LEN_W-1:0]      message_length,
	output logic                                is_last,
	output logic                                out_valid,
	input  wire logic                           out_ready
);
	import lpd_pkg::*;

	localparam int AW    = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);

	logic [DATA_W-1:0] start_marker_q;
	logic [LEN_W-1:0]  max_len_q;
	logic [LEN_W-1:0]  exp_len_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AW-1:0]     rd_idx_q;
	logic              out_valid_q;
	logic              out_last_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [7:0]        cnt_inc;
	logic [7:0]        rd_inc;
	logic [7:0]        depth_w;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			max_len_q      <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_MAX_LENGTH:   max_len_q      <= cfg_data[LEN_W-1:0];
				default:          start_marker_q <= start_marker_q;
			endcase
		end
	end

	// status compares
	assign depth_w = 8'(BUF_DEPTH);
	assign cnt_inc = 8'(cnt_q) + 8'd1;
	assign rd_inc  = 8'(rd_idx_q) + 8'd1;

	always_comb begin
		stat            = '0;
		stat.is_marker  = (rx_byte == start_marker_q);
		stat.is_zero    = (rx_byte == 8'd0);
		stat.too_long   = (rx_byte > {1'b0, max_len_q}) || (rx_byte > depth_w);
		stat.cnt_full   = (8'(cnt_q) >= depth_w);
		stat.frame_done = (cnt_inc == {1'b0, exp_len_q});
		stat.near_full  = (cnt_inc >= depth_w);
		stat.rd_last    = (rd_inc == {1'b0, exp_len_q});
		stat.out_free   = !out_valid_q || out_ready;
	end

	// frame length, byte count and readout index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
			cnt_q     <= '0;
			rd_idx_q  <= '0;
		end else begin
			if (cmd.latch_len) begin
				exp_len_q <= rx_byte[LEN_W-1:0];
				rd_idx_q  <= '0;
			end else if (cmd.emit_step) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word side fields
	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_last_q <= stat.rd_last;
			out_len_q  <= exp_len_q;
		end
	end

	// payload store, its read register doubles as the output byte
	lpd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(cnt_q[AW-1:0]),
		.wdata(rx_byte),
		.re   (cmd.emit_step),
		.raddr(rd_idx_q),
		.rdata(payload_byte)
	);

	assign message_length = out_len_q;
	assign is_last        = out_last_q;
	assign out_valid      = out_valid_q;

`ifndef SYNTHESIS
	// a readout never overwrites a word that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> (!out_valid_q || out_ready))
		else $error("output word overwritten while stalled");
	// stores stay inside the buffer
	a_store_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (8'(cnt_q) < depth_w))
		else $error("store beyond buffer depth");
	// last readout step shows up as a last word
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step && stat.rd_last) |=> (out_valid_q && out_last_q))
		else $error("last word not flagged");
	// no store and readout in the same cycle
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.store && cmd.emit_step))
		else $error("store during readout");
`endif

endmodule
`default_nettype wire

// ===== rtl/length_prefixed_packet_deframer_unit.sv =====
//  channel   signals                                  direction  handshake
//  input     rx_byte                                  in         in_valid / in_ready
//  output    payload_byte, message_length, is_last    out        out_valid / out_ready
//  config    cfg_index, cfg_data                      in         cfg_we, no wait
//
//  one input word per cycle while hunting, waiting for a length or receiving
//  a completed message of L bytes is read out of the payload RAM through its
//  single read port, one word per cycle unless stalled; input is held off meanwhile
//  a stalled output word holds in the RAM read register and pauses the readout
//  async reset: marker 126, max length 64, waiting for a length byte;
//  the payload RAM is not cleared
`default_nettype none
module length_prefixed_packet_deframer_unit #(
	parameter int BUF_DEPTH = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lpd_pkg::DATA_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lpd_pkg::DATA_W-1:0]    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lpd_pkg::DATA_W-1:0]    payload_byte,
	output logic      [lpd_pkg::LEN_W-1:0]     message_length,
	output logic                               is_last
);
	import lpd_pkg::*;

	lpd_cmd_t  cmd;
	lpd_stat_t stat;

	// framing controller
	lpd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// counters, store and output word
	lpd_dp #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.stat          (stat),
		.payload_byte  (payload_byte),
		.message_length(message_length),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready)
	);

endmodule
`default_nettype wire
